[rtl/arp_table_engine_core_macros.svh]
// Assertion macros used by the address resolution table core RTL.
// Needs i_clk and i_rst_n in the including module's scope.
`ifndef ARP_TABLE_ENGINE_CORE_MACROS_SVH
`define ARP_TABLE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/arpt_pkg.sv]
// Types and constants of the address resolution table.
// No dependencies.
`default_nettype none

package arpt_pkg;

    localparam int PROTO_W = 32;
    localparam int HW_W    = 48;
    localparam int SLOT_W  = 4;
    localparam int FUNC_W  = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD       = 2'd0,
        FUNC_LKP_PROTO = 2'd1,
        FUNC_LKP_HW    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/arpt_if.sv]
// Request and response channel interfaces of the address resolution table.
// Depends on arpt_pkg for field widths.
`default_nettype none

interface arpt_req_if;
    logic                         valid;
    logic                         ready;
    logic [arpt_pkg::FUNC_W-1:0]  func;
    logic [arpt_pkg::PROTO_W-1:0] proto_addr;
    logic [arpt_pkg::HW_W-1:0]    hw_addr;

    modport source (output valid, func, proto_addr, hw_addr, input ready);
    modport sink   (input valid, func, proto_addr, hw_addr, output ready);
endinterface

interface arpt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [arpt_pkg::SLOT_W-1:0]  slot;
    logic [arpt_pkg::PROTO_W-1:0] entry_proto;
    logic [arpt_pkg::HW_W-1:0]    entry_hw;

    modport source (output valid, status, slot, entry_proto, entry_hw, input ready);
    modport sink   (input valid, status, slot, entry_proto, entry_hw, output ready);
endinterface

`default_nettype wire

[rtl/arp_table_engine_core.sv]
// Address resolution table of ENTRIES address pairs; uses arpt_pkg, arpt_if, arpt_ram.
// A request word taken in idle starts a scan, which a hit ends early; a miss or a full
// table scans all ENTRIES slots, and an unused func code goes straight to done.
// The scan reads one slot a cycle; a new word is taken only in idle, after the result
// has moved to the output register, so a stalled o_rsp holds the next word off.
// Reset (synchronous, active low) marks every slot free at once; needs the macro header.
`default_nettype none

module arp_table_engine_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    arpt_req_if.sink   i_req,
    arpt_rsp_if.source o_rsp
);

    import arpt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    // Control state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_issue;       // next slot to read
    logic                   r_dv;          // read data of r_didx is present
    logic [ENTRIES-1:0]     r_valid;       // slot written since reset
    logic                   r_out_valid;

    // Request held for the scan
    t_func                  r_func;
    logic [PROTO_W-1:0]     r_pa;
    logic [HW_W-1:0]        r_ha;

    // Scan data stage
    logic [IDX_W-1:0]       r_didx;
    logic                   r_vbit;

    // Result waiting for the output register
    logic                   r_res_status;
    logic [SLOT_W-1:0]      r_res_slot;
    logic [PROTO_W-1:0]     r_res_proto;
    logic [HW_W-1:0]        r_res_hw;

    // Output register
    logic                   r_out_status;
    logic [SLOT_W-1:0]      r_out_slot;
    logic [PROTO_W-1:0]     r_out_proto;
    logic [HW_W-1:0]        r_out_hw;

    // Combinational control
    logic                   accept;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   hit;
    logic                   last;
    logic                   we;
    logic                   load_out;
    logic [PROTO_W-1:0]     ram_proto_q;
    logic [HW_W-1:0]        ram_hw_q;
    logic [PROTO_W-1:0]     cur_proto;
    logic [HW_W-1:0]        cur_hw;

    // Both stores share one address and one write strobe: a slot is always
    // written as a pair.
    arpt_ram #(.WIDTH(PROTO_W), .DEPTH(ENTRIES)) u_proto_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_didx),
        .i_wdata (r_pa),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_proto_q)
    );

    arpt_ram #(.WIDTH(HW_W), .DEPTH(ENTRIES)) u_hw_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_didx),
        .i_wdata (r_ha),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_hw_q)
    );

    // A slot never written since reset reads as zero, i.e. free.
    assign cur_proto = r_vbit ? ram_proto_q : '0;
    assign cur_hw    = r_vbit ? ram_hw_q    : '0;

    assign rd_addr = r_issue[IDX_W-1:0];
    assign last    = (r_didx == IDX_W'(ENTRIES - 1));

    // Control outputs
    always_comb begin
        accept   = i_req.valid && (r_state == ST_IDLE);
        rd_en    = (r_state == ST_SCAN) && (r_issue < CNT_W'(ENTRIES));
        hit      = 1'b0;
        if ((r_state == ST_SCAN) && r_dv) begin
            case (r_func)
                FUNC_ADD:       hit = (cur_proto == '0);
                FUNC_LKP_PROTO: hit = (cur_proto == r_pa);
                FUNC_LKP_HW:    hit = (cur_hw == r_ha);
                default:        hit = 1'b0;
            endcase
        end
        we       = hit && (r_func == FUNC_ADD);
        load_out = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_func'(i_req.func))
                        FUNC_ADD, FUNC_LKP_PROTO, FUNC_LKP_HW: n_state = ST_SCAN;
                        // unused code: answer the failure result straight away
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit || (r_dv && last)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= '0;
            r_dv        <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_en;
            if (accept) begin
                r_issue <= '0;
            end else if (rd_en) begin
                r_issue <= r_issue + CNT_W'(1);
            end
            if (we) begin
                r_valid[r_didx] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func       <= t_func'(i_req.func);
            r_pa         <= i_req.proto_addr;
            r_ha         <= i_req.hw_addr;
            // preset the failure word; a hit overwrites it
            r_res_status <= 1'b1;
            r_res_slot   <= '0;
            r_res_proto  <= '0;
            r_res_hw     <= '0;
        end else if (hit) begin
            r_res_status <= 1'b0;
            r_res_slot   <= SLOT_W'(r_didx);
            // an add reports the pair just written
            r_res_proto  <= (r_func == FUNC_ADD) ? r_pa : cur_proto;
            r_res_hw     <= (r_func == FUNC_ADD) ? r_ha : cur_hw;
        end
        if (rd_en) begin
            r_didx <= rd_addr;
            r_vbit <= r_valid[rd_addr];
        end
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_proto  <= r_res_proto;
            r_out_hw     <= r_res_hw;
        end
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.slot        = r_out_slot;
    assign o_rsp.entry_proto = r_out_proto;
    assign o_rsp.entry_hw    = r_out_hw;

`include "arp_table_engine_core_macros.svh"

    `ARPT_ASSERT_IMP(a_we_only_add, we, (r_state == ST_SCAN) && (r_func == FUNC_ADD), "write outside add scan")
    `ARPT_ASSERT_NXT(a_we_ends_scan, we, r_state == ST_DONE, "add did not finish after write")
    `ARPT_ASSERT_NXT(a_accept_leaves_idle, accept, r_state != ST_IDLE, "request taken but still idle")
    `ARPT_ASSERT_IMP(a_issue_bound, r_state == ST_SCAN, r_issue <= CNT_W'(ENTRIES), "scan ran past table")
    `ARPT_ASSERT_IMP(a_fail_zero, (r_state == ST_DONE) && r_res_status, (r_res_slot == '0) && (r_res_proto == '0) && (r_res_hw == '0), "failure word not zero")

endmodule

`default_nettype wire

[rtl/arpt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for arp_table_engine_core: directed and random request words,
// checked against an in-bench table model. Depends on arpt_pkg, arpt_if.sv and the core RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arpt_pkg::*;

    localparam int          TBL_ENTRIES  = 16;
    localparam int          RANDOM_WORDS = 1060;
    localparam int          IDLE_PCT     = 30;
    // Window of words during which neither side idles.
    localparam int          CALM_FIRST   = 450;
    localparam int          CALM_LAST    = 650;
    // func code the block leaves unassigned: it must answer a miss and change nothing.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic        STATUS_OK    = 1'b0;
    localparam logic        STATUS_MISS  = 1'b1;
    localparam logic [PROTO_W-1:0] PROTO_ONES = '1;
    localparam logic [HW_W-1:0]    HW_ONES    = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PROTO_W-1:0] proto_addr;
        logic [HW_W-1:0]    hw_addr;
        logic               drain;      // hold this word back until every answer is in
    } t_arp_cmd;

    typedef struct packed {
        logic               status;
        logic [SLOT_W-1:0]  slot;
        logic [PROTO_W-1:0] entry_proto;
        logic [HW_W-1:0]    entry_hw;
    } t_arp_result;

    logic i_clk;
    logic i_rst_n;

    arpt_req_if req_bus ();
    arpt_rsp_if rsp_bus ();

    arp_table_engine_core #(
        .ENTRIES (TBL_ENTRIES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow of the address table, updated as each request word is taken.
    logic [PROTO_W-1:0] proto_tbl [TBL_ENTRIES];
    logic [HW_W-1:0]    hw_tbl    [TBL_ENTRIES];

    t_arp_cmd    cmd_queue [$];        // words still to be offered
    t_arp_result lookup_results [$];   // answers owed by the block, oldest first

    logic req_taken;
    int   total_words;
    int   taken_cnt;
    int   sent_cnt;
    int   seen_cnt;
    int   fail_cnt;

    // Generator-side memory of addresses already added, so lookups can hit.
    logic [PROTO_W-1:0] known_proto [$];
    logic [HW_W-1:0]    known_hw    [$];

    // ------------------------------------------------------------------
    // Table model: lowest free slot for an add, lowest match for a lookup.
    // A protocol address of zero marks a free slot, so an add of zero
    // leaves the slot free and a lookup of zero finds the lowest free slot.
    // ------------------------------------------------------------------
    function automatic t_arp_result resolve_word(input logic [FUNC_W-1:0]  f,
                                                 input logic [PROTO_W-1:0] pa,
                                                 input logic [HW_W-1:0]    ha);
        t_arp_result res;
        int          hit;
        hit = -1;
        res = '{status: STATUS_MISS, slot: '0, entry_proto: '0, entry_hw: '0};
        case (f)
            FUNC_ADD: begin
                for (int i = 0; i < TBL_ENTRIES; i++)
                    if (hit < 0 && proto_tbl[i] == '0) hit = i;
                if (hit >= 0) begin
                    proto_tbl[hit] = pa;
                    hw_tbl[hit]    = ha;
                end
            end
            FUNC_LKP_PROTO: begin
                for (int i = 0; i < TBL_ENTRIES; i++)
                    if (hit < 0 && proto_tbl[i] == pa) hit = i;
            end
            FUNC_LKP_HW: begin
                // every slot is compared, free ones too
                for (int i = 0; i < TBL_ENTRIES; i++)
                    if (hit < 0 && hw_tbl[i] == ha) hit = i;
            end
            default: ;
        endcase
        if (hit >= 0) begin
            res.status      = STATUS_OK;
            res.slot        = SLOT_W'(hit);
            res.entry_proto = proto_tbl[hit];
            res.entry_hw    = hw_tbl[hit];
        end
        return res;
    endfunction

    function automatic logic [HW_W-1:0] random_hw();
        return HW_W'({$urandom, $urandom});
    endfunction

    task automatic queue_cmd(input logic [FUNC_W-1:0]  f,
                             input logic [PROTO_W-1:0] pa,
                             input logic [HW_W-1:0]    ha,
                             input logic               drain);
        cmd_queue.push_back('{func: f, proto_addr: pa, hw_addr: ha, drain: drain});
        if (f == FUNC_ADD) begin
            if (pa != '0) known_proto.push_back(pa);
            known_hw.push_back(ha);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        // hold every input at a known value from time zero
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.func       = '0;
        req_bus.proto_addr = '0;
        req_bus.hw_addr    = '0;
        rsp_bus.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: advance on the falling edge once the previous word
    // was taken at the rising edge before it; otherwise hold it steady.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_req
        t_arp_cmd cmd;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_taken) begin
            if (cmd_queue.size() != 0
                && !(cmd_queue[0].drain && lookup_results.size() != 0)
                && ((sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST)
                    || $urandom_range(99) >= IDLE_PCT)) begin
                cmd = cmd_queue.pop_front();
                req_bus.valid      <= 1'b1;
                req_bus.func       <= cmd.func;
                req_bus.proto_addr <= cmd.proto_addr;
                req_bus.hw_addr    <= cmd.hw_addr;
                sent_cnt++;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Take note of each accepted request word and predict its answer.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_bus.valid && req_bus.ready;
        if (i_rst_n && req_bus.valid && req_bus.ready) begin
            lookup_results.push_back(resolve_word(req_bus.func, req_bus.proto_addr,
                                                  req_bus.hw_addr));
            taken_cnt <= taken_cnt + 1;
        end
    end

    // ------------------------------------------------------------------
    // Response side: random back-pressure, drop it during the calm window.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= (seen_cnt >= CALM_FIRST && seen_cnt < CALM_LAST)
                             || $urandom_range(99) >= IDLE_PCT;
    end

    always @(posedge i_clk) begin : check_rsp
        t_arp_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            seen_cnt++;
            if (lookup_results.size() == 0) begin
                $error("response word with no request outstanding: status %0d slot %0d",
                       rsp_bus.status, rsp_bus.slot);
                fail_cnt++;
            end else begin
                want = lookup_results.pop_front();
                if (rsp_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                    fail_cnt++;
                end
                if (rsp_bus.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp_bus.slot);
                    fail_cnt++;
                end
                if (rsp_bus.entry_proto !== want.entry_proto) begin
                    $error("entry_proto: expected %h, got %h",
                           want.entry_proto, rsp_bus.entry_proto);
                    fail_cnt++;
                end
                if (rsp_bus.entry_hw !== want.entry_hw) begin
                    $error("entry_hw: expected %h, got %h", want.entry_hw, rsp_bus.entry_hw);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: fill the word queue, then wait for the table to go quiet.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [PROTO_W-1:0] pa;
        logic [HW_W-1:0]    ha;
        int                 r;
        int                 s;

        for (int i = 0; i < TBL_ENTRIES; i++) begin
            proto_tbl[i] = '0;
            hw_tbl[i]    = '0;
        end
        req_taken = 1'b0;
        taken_cnt = 0;
        sent_cnt  = 0;
        seen_cnt  = 0;
        fail_cnt  = 0;

        // Empty table: zero matches slot 0, all-ones misses.
        queue_cmd(FUNC_LKP_PROTO, '0, '0, 1'b0);
        queue_cmd(FUNC_LKP_HW, '0, '0, 1'b0);
        queue_cmd(FUNC_LKP_PROTO, PROTO_ONES, '0, 1'b0);
        queue_cmd(FUNC_LKP_HW, '0, HW_ONES, 1'b0);
        queue_cmd(FUNC_UNUSED, PROTO_ONES, HW_ONES, 1'b0);
        // Add of protocol zero: reported done, but the slot stays free.
        queue_cmd(FUNC_ADD, '0, 48'h0123_4567_89ab, 1'b0);
        queue_cmd(FUNC_LKP_HW, PROTO_ONES, 48'h0123_4567_89ab, 1'b0);
        queue_cmd(FUNC_LKP_PROTO, '0, HW_ONES, 1'b0);
        // ... so the next add overwrites it, here with all ones.
        queue_cmd(FUNC_ADD, PROTO_ONES, HW_ONES, 1'b0);
        queue_cmd(FUNC_LKP_PROTO, PROTO_ONES, '0, 1'b0);
        queue_cmd(FUNC_LKP_HW, '0, HW_ONES, 1'b0);
        queue_cmd(FUNC_UNUSED, '0, '0, 1'b0);
        // Duplicate protocol address: lookups return the lower slot.
        queue_cmd(FUNC_ADD, 32'd1, '0, 1'b0);
        queue_cmd(FUNC_LKP_HW, '0, '0, 1'b0);
        queue_cmd(FUNC_ADD, 32'd1, 48'd1, 1'b0);
        queue_cmd(FUNC_LKP_PROTO, 32'd1, '0, 1'b0);
        queue_cmd(FUNC_LKP_HW, '0, 48'd1, 1'b0);
        queue_cmd(FUNC_LKP_PROTO, '0, '0, 1'b0);

        // Random traffic: mostly lookups, a trickle of adds so the table
        // fills part way through and full-table adds get exercised too.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            r  = $urandom_range(99);
            s  = $urandom_range(99);
            pa = $urandom;
            ha = random_hw();
            if (r < 4) begin
                queue_cmd(FUNC_UNUSED, pa, ha, n == 300);
            end else if (r < 8) begin
                queue_cmd(FUNC_ADD, '0, ha, n == 300);
            end else if (r < 11) begin
                if (s < 50) pa = known_proto[$urandom_range(known_proto.size() - 1)];
                if (pa == '0) pa = 32'd1;
                queue_cmd(FUNC_ADD, pa, ha, n == 300);
            end else if (r < 56) begin
                if (s < 60)      pa = known_proto[$urandom_range(known_proto.size() - 1)];
                else if (s < 70) pa = '0;
                queue_cmd(FUNC_LKP_PROTO, pa, ha, n == 300 || n == 700);
            end else begin
                if (s < 60)      ha = known_hw[$urandom_range(known_hw.size() - 1)];
                else if (s < 70) ha = '0;
                else if (s < 75) ha = HW_ONES;
                queue_cmd(FUNC_LKP_HW, pa, ha, n == 700);
            end
        end

        // Close with a burst of adds to be sure the table reports full.
        for (int n = 0; n < TBL_ENTRIES + 2; n++) begin
            pa = $urandom;
            if (pa == '0) pa = PROTO_ONES;
            queue_cmd(FUNC_ADD, pa, random_hw(), 1'b0);
        end
        queue_cmd(FUNC_LKP_PROTO, '0, '0, 1'b0);
        queue_cmd(FUNC_LKP_PROTO, pa, '0, 1'b0);

        total_words = cmd_queue.size();

        @(posedge i_clk);
        while (taken_cnt < total_words || lookup_results.size() != 0)
            @(posedge i_clk);
        // allow a full scan for any stray answer to surface
        repeat (TBL_ENTRIES + 8) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
